/* hw/rtl/wildcard_signature_scan_defines.svh */
// ----------------------------------------------------------------------------
// wildcard signature scan assertion macros
// immediate-consequence and next-cycle implication checks
// ----------------------------------------------------------------------------
`ifndef WILDCARD_SIGNATURE_SCAN_DEFINES_SVH
`define WILDCARD_SIGNATURE_SCAN_DEFINES_SVH

// same-cycle implication
`define WSS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/wss_pkg.sv */
// ----------------------------------------------------------------------------
// wss_pkg
// shared types and constants of the wildcard signature scan
// ----------------------------------------------------------------------------
package wss_pkg;

   localparam int SIG_BYTES  = 16;
   localparam int CFG_DATA_W = 64;
   localparam int CFG_ADDR_W = 5;
   localparam int LEN_W      = 5;
   localparam int MASK_W     = 16;
   localparam int RSP_OFF_W  = 32;

   typedef enum logic [1:0] {
      REG_PATTERN_LOW,
      REG_PATTERN_HIGH,
      REG_WILDCARD_MASK,
      REG_PATTERN_LENGTH
   } reg_index_type;

   typedef struct packed {
      logic [63:0]         pattern_bytes_low;
      logic [63:0]         pattern_bytes_high;
      logic [MASK_W-1:0]   wildcard_mask;
      logic [LEN_W-1:0]    pattern_length;
   } cfg_type;

   typedef struct packed {
      logic                 found;
      logic [RSP_OFF_W-1:0] start_offset;
   } result_type;

endpackage

/* hw/rtl/wildcard_signature_scan.sv */
// ----------------------------------------------------------------------------
// wildcard_signature_scan
// streams image bytes through a wildcard signature compare, one result per image
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  req_      in         valid / stall       image_byte, last_byte
//  rsp_      out        valid / stall       found, start_offset
//  csr_      in         apb write / read    4 registers at 8-byte spacing
//
//  one request per cycle while req_stall is low; a result is queued at the
//  accepting edge, and the result channel shows a valid entry from the next cycle
//  two-entry result queue: req_stall rises only when both entries are held
//  synchronous reset clears registers, counters and the result queue
// ----------------------------------------------------------------------------
`include "wildcard_signature_scan_defines.svh"

module wildcard_signature_scan #(
   parameter int MAX_PATTERN = 16,
   parameter int OFFSET_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_image_byte,
   input  logic                           req_last_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic [wss_pkg::RSP_OFF_W-1:0]  rsp_start_offset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [wss_pkg::CFG_ADDR_W-1:0] csr_paddr,
   input  logic [wss_pkg::CFG_DATA_W-1:0] csr_pwdata,
   output logic [wss_pkg::CFG_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   wss_pkg::cfg_type    cfg;
   wss_pkg::result_type res;
   wss_pkg::result_type head;
   logic                accept;
   logic                res_push;
   logic                pop;
   logic                buf_full;

   assign accept    = req_valid && !buf_full;
   assign req_stall = buf_full;
   assign pop       = rsp_valid && !rsp_stall;

   assign rsp_found        = head.found;
   assign rsp_start_offset = head.start_offset;

   wss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   wss_match #(
      .MAX_PATTERN (MAX_PATTERN),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .image_byte (req_image_byte),
      .last_byte  (req_last_byte),
      .cfg        (cfg),
      .push       (res_push),
      .result     (res)
   );

   wss_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res),
      .pop       (pop),
      .head      (head),
      .valid     (rsp_valid),
      .full      (buf_full)
   );

   `WSS_ASSERT_IMPLY(a_stall_needs_pending, clock, reset,
      req_stall, rsp_valid, "stall with empty queue")
   `WSS_ASSERT_IMPLY(a_not_found_on_last, clock, reset,
      res_push && !res.found, req_last_byte, "not-found result before last byte")
   `WSS_ASSERT_IMPLY(a_not_found_zero_offset, clock, reset,
      rsp_valid && !rsp_found, rsp_start_offset == '0, "not-found result with offset")
   `WSS_ASSERT_NEXT(a_push_shows_result, clock, reset,
      res_push, rsp_valid, "queued result not offered")

endmodule

/* hw/rtl/wss_csr.sv */
// ----------------------------------------------------------------------------
// wss_csr
// register file for signature, wildcard mask and length
// ----------------------------------------------------------------------------
module wss_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [wss_pkg::CFG_ADDR_W-1:0] paddr,
   input  logic [wss_pkg::CFG_DATA_W-1:0] pwdata,
   output logic [wss_pkg::CFG_DATA_W-1:0] prdata,
   output logic                           pready,
   output wss_pkg::cfg_type               cfg
);

   wss_pkg::cfg_type       cfg_ff;
   wss_pkg::reg_index_type reg_index;
   logic                   wr_en;

   assign reg_index = wss_pkg::reg_index_type'(paddr[4:3]);
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_index)
            wss_pkg::REG_PATTERN_LOW:    cfg_ff.pattern_bytes_low  <= pwdata;
            wss_pkg::REG_PATTERN_HIGH:   cfg_ff.pattern_bytes_high <= pwdata;
            wss_pkg::REG_WILDCARD_MASK:
               cfg_ff.wildcard_mask  <= pwdata[wss_pkg::MASK_W-1:0];
            wss_pkg::REG_PATTERN_LENGTH:
               cfg_ff.pattern_length <= pwdata[wss_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_index)
         wss_pkg::REG_PATTERN_LOW:    prdata = cfg_ff.pattern_bytes_low;
         wss_pkg::REG_PATTERN_HIGH:   prdata = cfg_ff.pattern_bytes_high;
         wss_pkg::REG_WILDCARD_MASK:
            prdata = wss_pkg::CFG_DATA_W'(cfg_ff.wildcard_mask);
         wss_pkg::REG_PATTERN_LENGTH:
            prdata = wss_pkg::CFG_DATA_W'(cfg_ff.pattern_length);
         default: prdata = '0;
      endcase
   end

endmodule

/* hw/rtl/wss_match.sv */
// ----------------------------------------------------------------------------
// wss_match
// byte window, image byte counter and parallel wildcard compare
// ----------------------------------------------------------------------------
module wss_match #(
   parameter int MAX_PATTERN = 16,
   parameter int OFFSET_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           image_byte,
   input  logic                 last_byte,
   input  wss_pkg::cfg_type     cfg,
   output logic                 push,
   output wss_pkg::result_type  result
);

   localparam int SIG_W = 8 * wss_pkg::SIG_BYTES;

   logic [7:0]              window_ff [MAX_PATTERN];
   logic [7:0]              window_in [MAX_PATTERN];
   logic [OFFSET_BITS-1:0]  count_ff;
   logic [OFFSET_BITS-1:0]  count_in;
   logic                    reported_ff;
   logic                    reported_in;

   logic                    counted;
   logic [OFFSET_BITS-1:0]  new_count;
   logic [wss_pkg::LEN_W-1:0] len;
   logic                    len_ok;
   logic                    enough;
   logic [3:0]              shamt;
   logic [SIG_W-1:0]        sig_vec;
   logic [SIG_W-1:0]        rev_sig;
   logic [wss_pkg::MASK_W-1:0] rev_mask;
   logic [SIG_W-1:0]        aligned_sig;
   logic [wss_pkg::MASK_W-1:0] aligned_mask;
   logic [MAX_PATTERN-1:0]  pos_ok;
   logic                    match;
   logic [OFFSET_BITS-1:0]  diff;
   logic [63:0]             diff_wide;

   // newest byte enters at entry 0
   always_comb begin
      window_in[0] = image_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         window_in[j] = window_ff[j-1];
      end
   end

   assign counted   = (count_ff != '1);
   assign new_count = counted ? (count_ff + OFFSET_BITS'(1)) : count_ff;
   assign len       = cfg.pattern_length;
   assign len_ok    = (len != '0) && (len <= wss_pkg::LEN_W'(MAX_PATTERN));
   assign enough    = (new_count >= OFFSET_BITS'(len));
   assign shamt     = 4'(wss_pkg::LEN_W'(wss_pkg::SIG_BYTES) - len);
   assign sig_vec   = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};

   // reversed signature, shifted so window entry j lines up with byte len-1-j
   always_comb begin
      for (int k = 0; k < wss_pkg::SIG_BYTES; k++) begin
         rev_sig[8*k +: 8] = sig_vec[8*(wss_pkg::SIG_BYTES-1-k) +: 8];
         rev_mask[k]       = cfg.wildcard_mask[wss_pkg::SIG_BYTES-1-k];
      end
   end

   assign aligned_sig  = rev_sig >> {shamt, 3'b000};
   assign aligned_mask = rev_mask >> shamt;

   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pos_ok[j] = (wss_pkg::LEN_W'(j) >= len) || aligned_mask[j]
                  || (window_in[j] == aligned_sig[8*j +: 8]);
      end
   end

   assign match = !reported_ff && counted && len_ok && enough && (&pos_ok);

   assign diff      = new_count - OFFSET_BITS'(len);
   assign diff_wide = 64'(diff);

   assign push                = accept && (match || (last_byte && !reported_ff));
   assign result.found        = match;
   assign result.start_offset = match ? diff_wide[wss_pkg::RSP_OFF_W-1:0] : '0;

   always_comb begin
      count_in    = count_ff;
      reported_in = reported_ff;
      if (accept) begin
         if (last_byte) begin
            count_in    = '0;
            reported_in = 1'b0;
         end else begin
            count_in    = new_count;
            reported_in = reported_ff || match;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         reported_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         reported_ff <= reported_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

endmodule

/* hw/rtl/wss_out_buf.sv */
// ----------------------------------------------------------------------------
// wss_out_buf
// two-entry result queue between the compare and the result channel
// ----------------------------------------------------------------------------
module wss_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wss_pkg::result_type push_data,
   input  logic                pop,
   output wss_pkg::result_type head,
   output logic                valid,
   output logic                full
);

   wss_pkg::result_type head_ff;
   wss_pkg::result_type head_in;
   wss_pkg::result_type tail_ff;
   wss_pkg::result_type tail_in;
   logic [1:0]          count_ff;
   logic [1:0]          count_in;

   assign head  = head_ff;
   assign valid = (count_ff != 2'd0);
   assign full  = (count_ff == 2'd2);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      unique case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            head_in = push_data;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule
